### hw/rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and helpers of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int VAL_W = 48;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_ADD   = 3'd1,
		OP_SUB   = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4,
		OP_MOD   = 3'd5,
		OP_PRINT = 3'd6,
		OP_UNK   = 3'd7
	} op_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [VAL_W-1:0] operand_value;
	} token_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] printed_value;
		logic                    printed;
		logic [1:0]              underflow_count;
		logic                    overflow;
		logic                    zero_divisor;
		logic                    unknown_command;
		logic [7:0]              stack_depth;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RD_B,
		ST_GET_B,
		ST_RD_A,
		ST_GET_A,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_PUSH_RES,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic cap_b;
		logic cap_a;
		logic set_print;
		logic set_zdiv;
		logic set_unk;
		logic mul_init;
		logic mul_step;
		logic div_load;
		logic div_step;
		logic push;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic b_zero;
		logic b_int_zero;
		logic mul_last;
		logic div_last;
	} ctl_sts_t;

	// partial products of the 24x24 multiplier
	localparam logic [2:0] MUL_STEPS = 3'd4;

	// saturate a sign and magnitude to the 48-bit signed range
	function automatic logic [VAL_W-1:0] sat_mag(input logic neg, input logic [127:0] mag);
		logic [127:0]      lim;
		logic [VAL_W-1:0]  m;
		lim = neg ? (128'd1 << (VAL_W-1)) : ((128'd1 << (VAL_W-1)) - 128'd1);
		m   = (mag > lim) ? lim[VAL_W-1:0] : mag[VAL_W-1:0];
		return neg ? (VAL_W)'(-m) : m;
	endfunction

	function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? (VAL_W)'(-v) : v;
	endfunction

endpackage

### hw/rtl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_ctrl
// Sequencer: pops operands, runs the arithmetic unit, pushes, reports.
// ----------------------------------------------------------------------------
module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.op == OP_PUSH) begin
					cmd.push = 1'b1;
					state_d  = ST_FIN;
				end else if (sts.op == OP_UNK) begin
					cmd.set_unk = 1'b1;
					state_d     = ST_FIN;
				end else begin
					state_d = ST_RD_B;
				end
			end
			ST_RD_B: begin
				cmd.rd  = 1'b1;
				state_d = ST_GET_B;
			end
			ST_GET_B: begin
				cmd.cap_b = 1'b1;
				if (sts.op == OP_PRINT) begin
					cmd.set_print = 1'b1;
					state_d       = ST_FIN;
				end else if ((sts.op == OP_DIV && sts.b_zero) ||
				             (sts.op == OP_MOD && sts.b_int_zero)) begin
					cmd.set_zdiv = 1'b1;
					state_d      = ST_FIN;
				end else begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: begin
				cmd.rd  = 1'b1;
				state_d = ST_GET_A;
			end
			ST_GET_A: begin
				cmd.cap_a = 1'b1;
				state_d   = ST_PREP;
			end
			ST_PREP: begin
				if (sts.op == OP_MUL) begin
					cmd.mul_init = 1'b1;
					state_d      = ST_MUL;
				end else if (sts.op == OP_DIV || sts.op == OP_MOD) begin
					cmd.div_load = 1'b1;
					state_d      = ST_DIV;
				end else begin
					cmd.push = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_d = ST_PUSH_RES;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_PUSH_RES;
			end
			ST_PUSH_RES: begin
				cmd.push = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hw/rtl/rpn_dpath.sv
// ----------------------------------------------------------------------------
// rpn_dpath
// Value stack, operand registers, multiplier, restoring divider, result word.
// ----------------------------------------------------------------------------
module rpn_dpath
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 128,
	parameter int FRAC_BITS   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  token_t   token,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output result_t  result,
	output logic     done
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW  = VAL_W + FRAC_BITS;
	localparam int CW  = $clog2(DW + 1);

	logic [VAL_W-1:0] mem [STACK_DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic             rd_empty_q;

	logic [SPW-1:0]   sp_q;
	op_t              op_q;
	logic [VAL_W-1:0] operand_q;
	logic [VAL_W-1:0] a_q, b_q;
	logic [1:0]       und_q;
	logic             ovf_q, zdiv_q, unk_q, printed_q;
	logic [VAL_W-1:0] pval_q;

	logic [2:0]       mcnt_q;
	logic [1:0]       pidx_q;
	logic [47:0]      prod_q;
	logic [95:0]      acc_q;

	logic [DW-1:0]    quo_q;
	logic [VAL_W-1:0] rem_q, dvs_q;
	logic [CW-1:0]    dcnt_q;

	result_t          res_q;
	logic             done_q;

	logic [VAL_W-1:0] pop_data, ma, mb, pop_mag, push_val;
	logic [23:0]      a_half, b_half;
	logic [95:0]      pp_sh;
	logic [VAL_W:0]   trial, sum;
	logic             full, res_neg;
	logic [VAL_W-1:0] r_shift;

	assign pop_data = rd_empty_q ? '0 : rdata_q;
	assign pop_mag  = mag_of(pop_data);
	assign ma       = mag_of(a_q);
	assign mb       = mag_of(b_q);
	assign full     = (sp_q >= SPW'(STACK_DEPTH));
	assign res_neg  = a_q[VAL_W-1] ^ b_q[VAL_W-1];

	assign sts.op         = op_q;
	assign sts.b_zero     = (pop_data == '0);
	assign sts.b_int_zero = ((pop_mag >> FRAC_BITS) == '0);
	assign sts.mul_last   = (mcnt_q == MUL_STEPS);
	assign sts.div_last   = (dcnt_q == CW'(1));

	// multiplier operand halves and shifted partial product
	assign a_half = mcnt_q[0] ? ma[47:24] : ma[23:0];
	assign b_half = mcnt_q[1] ? mb[47:24] : mb[23:0];

	always_comb begin
		unique case (pidx_q)
			2'd0:       pp_sh = 96'(prod_q);
			2'd1, 2'd2: pp_sh = 96'(prod_q) << 24;
			2'd3:       pp_sh = 96'(prod_q) << 48;
			default:    pp_sh = '0;
		endcase
	end

	assign trial = {rem_q, quo_q[DW-1]};
	assign sum   = (op_q == OP_SUB) ? ({a_q[VAL_W-1], a_q} - {b_q[VAL_W-1], b_q})
	                                : ({a_q[VAL_W-1], a_q} + {b_q[VAL_W-1], b_q});
	assign r_shift = rem_q << FRAC_BITS;

	always_comb begin
		unique case (op_q)
			OP_PUSH: push_val = operand_q;
			OP_ADD, OP_SUB: begin
				if (sum[VAL_W] != sum[VAL_W-1])
					push_val = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
				else
					push_val = sum[VAL_W-1:0];
			end
			OP_MUL:  push_val = sat_mag(res_neg, 128'(acc_q >> FRAC_BITS));
			OP_DIV:  push_val = sat_mag(res_neg, 128'(quo_q));
			OP_MOD:  push_val = a_q[VAL_W-1] ? (VAL_W)'(-r_shift) : r_shift;
			default: push_val = '0;
		endcase
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (cmd.push && !full) mem[AW'(sp_q)] <= push_val;
		if (cmd.rd) rdata_q <= mem[AW'(sp_q - SPW'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q       <= '0;
			rd_empty_q <= 1'b0;
			und_q      <= '0;
			ovf_q      <= 1'b0;
			zdiv_q     <= 1'b0;
			unk_q      <= 1'b0;
			printed_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				und_q     <= '0;
				ovf_q     <= 1'b0;
				zdiv_q    <= 1'b0;
				unk_q     <= 1'b0;
				printed_q <= 1'b0;
			end
			if (cmd.rd) begin
				if (sp_q != '0) begin
					sp_q       <= sp_q - SPW'(1);
					rd_empty_q <= 1'b0;
				end else begin
					und_q      <= und_q + 2'd1;
					rd_empty_q <= 1'b1;
				end
			end
			if (cmd.push) begin
				if (full) ovf_q <= 1'b1;
				else      sp_q  <= sp_q + SPW'(1);
			end
			if (cmd.set_zdiv)  zdiv_q    <= 1'b1;
			if (cmd.set_unk)   unk_q     <= 1'b1;
			if (cmd.set_print) printed_q <= 1'b1;
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= token.operation;
			operand_q <= token.operand_value;
			pval_q    <= '0;
		end
		if (cmd.cap_b)     b_q    <= pop_data;
		if (cmd.cap_a)     a_q    <= pop_data;
		if (cmd.set_print) pval_q <= pop_data;

		if (cmd.mul_init) begin
			mcnt_q <= '0;
			acc_q  <= '0;
		end else if (cmd.mul_step) begin
			if (mcnt_q < MUL_STEPS) begin
				prod_q <= a_half * b_half;
				pidx_q <= mcnt_q[1:0];
			end
			if (mcnt_q != '0) acc_q <= acc_q + pp_sh;
			mcnt_q <= mcnt_q + 3'd1;
		end

		if (cmd.div_load) begin
			rem_q  <= '0;
			dcnt_q <= CW'(DW);
			if (op_q == OP_MOD) begin
				quo_q <= DW'(ma >> FRAC_BITS);
				dvs_q <= mb >> FRAC_BITS;
			end else begin
				quo_q <= DW'(ma) << FRAC_BITS;
				dvs_q <= mb;
			end
		end else if (cmd.div_step) begin
			// restoring step: one quotient bit per cycle
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= VAL_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[VAL_W-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - CW'(1);
		end

		if (cmd.finish) begin
			res_q.printed_value   <= pval_q;
			res_q.printed         <= printed_q;
			res_q.underflow_count <= und_q;
			res_q.overflow        <= ovf_q;
			res_q.zero_divisor    <= zdiv_q;
			res_q.unknown_command <= unk_q;
			res_q.stack_depth     <= 8'(sp_q);
		end
	end

	assign result = res_q;
	assign done   = done_q;

`ifndef SYNTH
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");
	a_und_max: assert property (@(posedge clk) disable iff (!arst_n)
		und_q != 2'd3)
		else $error("more than two empty pops");
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && full |=> ovf_q && $stable(sp_q))
		else $error("push on full stack not dropped");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd && sp_q == '0 |=> rd_empty_q && sp_q == '0)
		else $error("empty pop mishandled");
`endif

endmodule

### hw/rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish evaluator on a stack of signed Q31.16 words.
//
//  channel | handshake       | word
//  --------+-----------------+----------------------------------
//  token   | start / busy    | operation, operand_value
//  result  | done (strobe)   | printed_value, flags, stack_depth
//
// Push, unknown command, print and zero divisor use no arithmetic unit; add/sub is
// combinational; mul steps the multiplier and div/mod the one-bit-per-cycle divider
// over 48 + FRAC_BITS quotient bits. done pulses for one cycle after the item; busy
// drops in that same cycle, so the next word can be taken while done is high.
// Reset clears the stack pointer and control; stack contents are not cleared.
// The receiver cannot stall: each result word is valid only while done is high.
// ----------------------------------------------------------------------------
module rpn_stack_calculator
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 128,
	parameter int FRAC_BITS   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  token_t  token,
	output result_t result,
	output logic    done
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	rpn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	rpn_dpath #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.token  (token),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

endmodule
